// ===== design/bci_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bci_pkg
// Shared widths, status codes and pipeline types of the cell interpolator.
// ----------------------------------------------------------------------------
package bci_pkg;

   localparam int CW    = 32;        // field width
   localparam int MW    = 32;        // magnitude of a coordinate difference
   localparam int PW    = 64;        // 32x32 product
   localparam int TW    = 96;        // magnitude of one weighted term
   localparam int SW    = 98;        // signed numerator
   localparam int NW    = 97;        // numerator magnitude
   localparam int QW    = 33;        // quotient bits kept after the overflow test
   localparam int TOLW  = 16;
   localparam int DSTG  = QW;        // one quotient bit per divider stage

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_X_OOB = 2'd1;
   localparam logic [1:0] ST_Y_OOB = 2'd2;
   localparam logic [1:0] ST_DEGEN = 2'd3;

   typedef struct packed {
      logic signed [CW-1:0] x_low;
      logic signed [CW-1:0] y_low;
      logic signed [CW-1:0] x_high;
      logic signed [CW-1:0] y_high;
      logic signed [CW-1:0] value_bottom_left;
      logic signed [CW-1:0] value_bottom_right;
      logic signed [CW-1:0] value_top_left;
      logic signed [CW-1:0] value_top_right;
      logic signed [CW-1:0] target_x;
      logic signed [CW-1:0] target_y;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] status;
      logic       degen;
   } ctl_type;

   // term k: 0 bottom left, 1 bottom right, 2 top left, 3 top right
   typedef struct packed {
      logic [3:0][MW-1:0] qmag;
      logic [3:0]         tneg;
      logic [MW-1:0]      dx0;   // x_high - target_x
      logic [MW-1:0]      dx1;   // target_x - x_low
      logic [MW-1:0]      dy0;   // y_high - target_y
      logic [MW-1:0]      dy1;   // target_y - y_low
      logic [MW-1:0]      wx;
      logic [MW-1:0]      wy;
      logic               dneg;
   } geo_type;

   typedef struct packed {
      logic [NW-1:0] num;
      logic [PW-1:0] den;
      logic          neg;
   } frac_type;

   function automatic logic [MW-1:0] abs33(input logic signed [MW:0] v);
      logic signed [MW:0] n;
      n = -v;
      return v[MW] ? n[MW-1:0] : v[MW-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== design/bci_chan_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bci_req_if / bci_rsp_if
// Valid/ready channels carrying a cell item and an interpolation result.
// ----------------------------------------------------------------------------
interface bci_req_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] x_low;
   logic signed [31:0] y_low;
   logic signed [31:0] x_high;
   logic signed [31:0] y_high;
   logic signed [31:0] value_bottom_left;
   logic signed [31:0] value_bottom_right;
   logic signed [31:0] value_top_left;
   logic signed [31:0] value_top_right;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;

   modport source (output valid, x_low, y_low, x_high, y_high, value_bottom_left,
                   value_bottom_right, value_top_left, value_top_right, target_x,
                   target_y, input ready);
   modport sink   (input valid, x_low, y_low, x_high, y_high, value_bottom_left,
                   value_bottom_right, value_top_left, value_top_right, target_x,
                   target_y, output ready);
endinterface

interface bci_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] interpolated;
   logic [1:0]         status;

   modport source (output valid, interpolated, status, input ready);
   modport sink   (input valid, interpolated, status, output ready);
endinterface
`default_nettype wire

// ===== design/bilinear_cell_interpolator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_cell_interpolator
// Bilinear interpolation of one axis-aligned cell at one point, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  : one cell (corners, corner values) and a target point per transfer.
//   rsp_ch  : interpolated value (saturated) and status per transfer:
//             ok, x out of bounds, y out of bounds, degenerate cell.
//   csr_*   : write of the bound tolerance; always ready, write only when idle.
//   Stages from request transfer to response: 1 stage of differences, 7 of
//   products and add tree, 1 overflow test, 33 divider stages (one quotient
//   bit each), 1 rounding stage, 1 output register.
//   Throughput one item per cycle unless rsp_ch.ready is low with a result
//   held; the 33-stage restoring divider sets the depth.
//   Reset clears all stage valid bits and the tolerance to zero.
//   When rsp_ch.ready is low with a result held, the whole pipeline freezes
//   and req_ch.ready falls; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module bilinear_cell_interpolator
   import bci_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   bci_req_if.sink              req_ch,
   bci_rsp_if.source            rsp_ch,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [TOLW-1:0] csr_data
);

   logic               adv;
   logic [TOLW-1:0]    tol_ff;
   item_type           item;
   ctl_type            c1, c2, c3;
   geo_type            geo;
   frac_type           frac;
   logic               neg, ovf;
   logic [QW:0]        quo;
   logic               rsp_valid_ff;
   logic signed [CW-1:0] res_ff, res_in;
   logic [1:0]         status_ff;
   logic [CW-1:0]      nq;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign csr_ready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   always_comb begin
      item.x_low              = req_ch.x_low;
      item.y_low              = req_ch.y_low;
      item.x_high             = req_ch.x_high;
      item.y_high             = req_ch.y_high;
      item.value_bottom_left  = req_ch.value_bottom_left;
      item.value_bottom_right = req_ch.value_bottom_right;
      item.value_top_left     = req_ch.value_top_left;
      item.value_top_right    = req_ch.value_top_right;
      item.target_x           = req_ch.target_x;
      item.target_y           = req_ch.target_y;
   end

   bci_front u_front (
      .clock, .reset, .adv,
      .in_valid (req_ch.valid),
      .item,
      .tol      (tol_ff),
      .ctl_ff   (c1),
      .geo_ff   (geo)
   );

   bci_numer u_numer (
      .clock, .reset, .adv,
      .ctl     (c1),
      .geo,
      .ctl_ff  (c2),
      .frac_ff (frac)
   );

   bci_div u_div (
      .clock, .reset, .adv,
      .ctl    (c2),
      .frac,
      .ctl_ff (c3),
      .neg_ff (neg),
      .ovf_ff (ovf),
      .quo_ff (quo)
   );

   // saturate to signed 32 bits; a degenerate cell gives zero
   always_comb begin
      nq = -quo[CW-1:0];
      if (c3.degen) begin
         res_in = '0;
      end else if (neg) begin
         res_in = (ovf || quo > {3'b001, {(QW-2){1'b0}}}) ? {1'b1, {(CW-1){1'b0}}}
                                                          : nq;
      end else begin
         res_in = (ovf || quo > {3'b000, {(QW-2){1'b1}}}) ? {1'b0, {(CW-1){1'b1}}}
                                                          : quo[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= c3.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff    <= res_in;
         status_ff <= c3.status;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.interpolated = res_ff;
   assign rsp_ch.status       = status_ff;

endmodule
`default_nettype wire

// ===== design/bci_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bci_front
// Coordinate differences, magnitudes, term signs, and bound and degenerate status.
// ----------------------------------------------------------------------------
module bci_front
   import bci_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            adv,
   input  wire logic            in_valid,
   input  wire item_type        item,
   input  wire logic [TOLW-1:0] tol,
   output ctl_type              ctl_ff,
   output geo_type              geo_ff
);

   logic signed [MW:0]   dx0, dx1, dy0, dy1, wx, wy;
   logic signed [MW+1:0] xl_e, xh_e, yl_e, yh_e, tx_e, ty_e, tol_e;
   logic                 x_oob, y_oob;
   ctl_type              ctl_in;
   geo_type              geo_in;

   always_comb begin
      dx0 = {item.x_high[31], item.x_high} - {item.target_x[31], item.target_x};
      dx1 = {item.target_x[31], item.target_x} - {item.x_low[31], item.x_low};
      dy0 = {item.y_high[31], item.y_high} - {item.target_y[31], item.target_y};
      dy1 = {item.target_y[31], item.target_y} - {item.y_low[31], item.y_low};
      wx  = {item.x_high[31], item.x_high} - {item.x_low[31], item.x_low};
      wy  = {item.y_high[31], item.y_high} - {item.y_low[31], item.y_low};

      xl_e  = {{2{item.x_low[31]}}, item.x_low};
      xh_e  = {{2{item.x_high[31]}}, item.x_high};
      yl_e  = {{2{item.y_low[31]}}, item.y_low};
      yh_e  = {{2{item.y_high[31]}}, item.y_high};
      tx_e  = {{2{item.target_x[31]}}, item.target_x};
      ty_e  = {{2{item.target_y[31]}}, item.target_y};
      tol_e = {{(MW+2-TOLW){1'b0}}, tol};
      x_oob = (tx_e < xl_e - tol_e) || (tx_e > xh_e + tol_e);
      y_oob = (ty_e < yl_e - tol_e) || (ty_e > yh_e + tol_e);

      ctl_in.valid  = in_valid;
      ctl_in.degen  = (wx == '0) || (wy == '0);
      ctl_in.status = ctl_in.degen ? ST_DEGEN :
                      x_oob        ? ST_X_OOB :
                      y_oob        ? ST_Y_OOB : ST_OK;

      geo_in.qmag[0] = abs33({item.value_bottom_left[31],  item.value_bottom_left});
      geo_in.qmag[1] = abs33({item.value_bottom_right[31], item.value_bottom_right});
      geo_in.qmag[2] = abs33({item.value_top_left[31],     item.value_top_left});
      geo_in.qmag[3] = abs33({item.value_top_right[31],    item.value_top_right});
      geo_in.tneg[0] = item.value_bottom_left[31]  ^ dx0[MW] ^ dy0[MW];
      geo_in.tneg[1] = item.value_bottom_right[31] ^ dx1[MW] ^ dy0[MW];
      geo_in.tneg[2] = item.value_top_left[31]     ^ dx0[MW] ^ dy1[MW];
      geo_in.tneg[3] = item.value_top_right[31]    ^ dx1[MW] ^ dy1[MW];
      geo_in.dx0  = abs33(dx0);
      geo_in.dx1  = abs33(dx1);
      geo_in.dy0  = abs33(dy0);
      geo_in.dy1  = abs33(dy1);
      geo_in.wx   = abs33(wx);
      geo_in.wy   = abs33(wy);
      geo_in.dneg = wx[MW] ^ wy[MW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         geo_ff <= geo_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/bci_numer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bci_numer
// Weighted corner sum and cell area: 32x32 products, split wide product,
// sign, two-level add tree, magnitude.
// ----------------------------------------------------------------------------
module bci_numer
   import bci_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    adv,
   input  wire ctl_type ctl,
   input  wire geo_type geo,
   output ctl_type      ctl_ff,
   output frac_type     frac_ff
);

   localparam int NST = 6;

   // control and denominator travel with the data
   ctl_type       c_ff   [0:NST-1];
   logic [PW-1:0] den_ff [0:NST-1];
   logic          dneg_ff[0:NST-1];

   logic [3:0][PW-1:0]      p_ff;
   logic [3:0][MW-1:0]      dy_ff;
   logic [3:0]              tneg2_ff, tneg3_ff, tneg4_ff;
   logic [3:0][PW-1:0]      lo_ff, hi_ff;
   logic [3:0][TW-1:0]      m_ff;
   logic signed [SW-1:0]    t_ff [0:3];
   logic signed [SW-1:0]    s_ff [0:1];
   logic signed [SW-1:0]    sum_ff;
   logic signed [SW-1:0]    neg_sum;
   frac_type                frac_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) c_ff[i] <= '0;
         ctl_ff <= '0;
      end else if (adv) begin
         c_ff[0] <= ctl;
         for (int i = 1; i < NST; i++) c_ff[i] <= c_ff[i-1];
         ctl_ff <= c_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff[0]  <= geo.wx * geo.wy;
         dneg_ff[0] <= geo.dneg;
         for (int i = 1; i < NST; i++) begin
            den_ff[i]  <= den_ff[i-1];
            dneg_ff[i] <= dneg_ff[i-1];
         end

         // first product |q| * |dx|
         p_ff[0]  <= geo.qmag[0] * geo.dx0;
         p_ff[1]  <= geo.qmag[1] * geo.dx1;
         p_ff[2]  <= geo.qmag[2] * geo.dx0;
         p_ff[3]  <= geo.qmag[3] * geo.dx1;
         dy_ff[0] <= geo.dy0;
         dy_ff[1] <= geo.dy0;
         dy_ff[2] <= geo.dy1;
         dy_ff[3] <= geo.dy1;
         tneg2_ff <= geo.tneg;

         // 64x32 as two 32x32 halves
         for (int k = 0; k < 4; k++) begin
            lo_ff[k] <= p_ff[k][MW-1:0]  * dy_ff[k];
            hi_ff[k] <= p_ff[k][PW-1:MW] * dy_ff[k];
         end
         tneg3_ff <= tneg2_ff;

         for (int k = 0; k < 4; k++) begin
            m_ff[k] <= {hi_ff[k], {MW{1'b0}}} + {{MW{1'b0}}, lo_ff[k]};
         end
         tneg4_ff <= tneg3_ff;

         for (int k = 0; k < 4; k++) begin
            t_ff[k] <= tneg4_ff[k] ? -$signed({2'b00, m_ff[k]})
                                   :  $signed({2'b00, m_ff[k]});
         end

         s_ff[0] <= t_ff[0] + t_ff[1];
         s_ff[1] <= t_ff[2] + t_ff[3];
         sum_ff  <= s_ff[0] + s_ff[1];

         frac_ff <= frac_in;
      end
   end

   always_comb begin
      neg_sum     = -sum_ff;
      frac_in.num = sum_ff[SW-1] ? neg_sum[NW-1:0] : sum_ff[NW-1:0];
      frac_in.den = den_ff[NST-1];
      frac_in.neg = sum_ff[SW-1] ^ dneg_ff[NST-1];
   end

endmodule
`default_nettype wire

// ===== design/bci_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bci_div
// Overflow test, restoring divider (one quotient bit per stage), rounding to
// nearest with ties away from zero.
// ----------------------------------------------------------------------------
module bci_div
   import bci_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    adv,
   input  wire ctl_type ctl,
   input  wire frac_type frac,
   output ctl_type      ctl_ff,
   output logic         neg_ff,
   output logic         ovf_ff,
   output logic [QW:0]  quo_ff
);

   typedef struct packed {
      ctl_type       ctl;
      logic          neg;
      logic          ovf;
      logic [PW-1:0] rem;
      logic [QW-1:0] low;
      logic [QW-1:0] quo;
      logic [PW-1:0] den;
   } dstage_type;

   dstage_type st_ff [0:DSTG];
   dstage_type st_in [0:DSTG];
   logic       rnd;

   // quotient bits above the kept range mean saturation
   always_comb begin
      st_in[0].ctl = ctl;
      st_in[0].neg = frac.neg;
      st_in[0].ovf = frac.num >= {frac.den, {QW{1'b0}}};
      st_in[0].rem = frac.num[NW-1:QW];
      st_in[0].low = frac.num[QW-1:0];
      st_in[0].quo = '0;
      st_in[0].den = frac.den;
   end

   for (genvar j = 1; j <= DSTG; j++) begin : g_stage
      logic [PW:0] trial;
      always_comb begin
         trial    = {st_ff[j-1].rem, st_ff[j-1].low[DSTG-j]};
         st_in[j] = st_ff[j-1];
         if (trial >= {1'b0, st_ff[j-1].den}) begin
            trial                = trial - {1'b0, st_ff[j-1].den};
            st_in[j].quo[DSTG-j] = 1'b1;
         end
         st_in[j].rem = trial[PW-1:0];
      end
   end

   for (genvar j = 0; j <= DSTG; j++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[j].ctl <= '0;
         end else if (adv) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   // round up when the remainder is at least half the divisor
   assign rnd = {st_ff[DSTG].rem, 1'b0} >= {1'b0, st_ff[DSTG].den};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= st_ff[DSTG].ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ff <= st_ff[DSTG].neg;
         ovf_ff <= st_ff[DSTG].ovf;
         quo_ff <= {1'b0, st_ff[DSTG].quo} + {{QW{1'b0}}, rnd};
      end
   end

endmodule
`default_nettype wire
